FILE: design/ntc_d2t_pkg.sv
// Shared constants and types for the NTC duty-to-temperature pipeline.
`default_nettype none
package ntc_d2t_pkg;

	localparam int DUTY_WIDTH_DEF = 16;
	localparam int LOG_FRAC       = 30;
	localparam int MANT_W         = LOG_FRAC + 1;
	localparam int REM_W          = 62;
	localparam int QUOT_W         = 16;
	localparam int CFG_DATA_W     = 17;

	localparam logic [23:0] K_T25_LN2      = 24'd13543790;
	localparam logic [14:0] T25_CENTI_K    = 15'd29815;
	localparam logic [15:0] ZERO_C_CENTI_K = 16'd27315;
	localparam logic [14:0] TEMP_MAX_CENTI = 15'd20000;
	localparam logic [15:0] SAT_LIMIT      = 16'd47316;

	localparam logic [15:0] DUTY_MIN_RST = 16'd3277;
	localparam logic [15:0] DUTY_MAX_RST = 16'd62259;
	localparam logic [16:0] R25_RST      = 17'd5000;
	localparam logic [13:0] BETA_RST     = 14'd3523;

	typedef enum logic [1:0] {
		REG_DUTY_MIN = 2'd0,
		REG_DUTY_MAX = 2'd1,
		REG_R25      = 2'd2,
		REG_BETA     = 2'd3
	} cfg_reg_t;

	// Per-item control that travels with the data.
	typedef struct packed {
		logic vld;
		logic ok;
	} ctl_t;

endpackage
`default_nettype wire

FILE: design/ntc_d2t_front.sv
// Front end: window check, divider terms, leading-one search and normalization.
`default_nettype none
module ntc_d2t_front #(
	parameter int DUTY_WIDTH = ntc_d2t_pkg::DUTY_WIDTH_DEF,
	parameter int XW = DUTY_WIDTH + 23,
	parameter int EW = $clog2(XW)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   adv,
	input  wire logic                   in_vld,
	input  wire logic [DUTY_WIDTH-1:0]  duty,
	input  wire logic [15:0]            duty_min,
	input  wire logic [15:0]            duty_max,
	input  wire logic [16:0]            r25,
	output ntc_d2t_pkg::ctl_t           ctl_s3,
	output logic [EW-1:0]               e1_s3,
	output logic [EW-1:0]               e2_s3,
	output logic [ntc_d2t_pkg::MANT_W-1:0] m1_s3,
	output logic [ntc_d2t_pkg::MANT_W-1:0] m2_s3
);
	localparam int CW = (DUTY_WIDTH > 16) ? DUTY_WIDTH : 16;
	localparam int MW = ntc_d2t_pkg::MANT_W;

	function automatic logic [EW-1:0] msb_pos(input logic [XW-1:0] x);
		logic [EW-1:0] p;
		p = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i])
				p = EW'(i);
		end
		return p;
	endfunction

	function automatic logic [MW-1:0] normalize(input logic [XW-1:0] x,
		input logic [EW-1:0] e);
		logic [XW+MW-1:0] ext;
		logic [EW-1:0]    sh;
		ext = {x, {MW{1'b0}}};
		sh  = EW'(XW - 1) - e;
		ext = ext << sh;
		return ext[XW+MW-1 -: MW];
	endfunction

	ntc_d2t_pkg::ctl_t ctl_s1, ctl_s2;
	logic [XW-1:0] x1_s1, x2_s1, x1_s2, x2_s2;
	logic [EW-1:0] e1_s2, e2_s2;
	logic [CW-1:0] d_c;
	logic [XW-1:0] a_c, b_c;

	assign d_c = CW'(duty);
	assign a_c = (XW'(9) << DUTY_WIDTH) - (XW'(duty) << 3);
	assign b_c = (XW'(9) << DUTY_WIDTH) + (XW'(duty) << 5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1.vld <= in_vld;
			ctl_s1.ok  <= (d_c >= CW'(duty_min)) && (d_c <= CW'(duty_max));
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x1_s1 <= a_c * XW'(3960);
			x2_s1 <= b_c * XW'(r25);
			x1_s2 <= x1_s1;
			x2_s2 <= x2_s1;
			e1_s2 <= msb_pos(x1_s1);
			e2_s2 <= msb_pos(x2_s1);
			e1_s3 <= e1_s2;
			e2_s3 <= e2_s2;
			m1_s3 <= normalize(x1_s2, e1_s2);
			m2_s3 <= normalize(x2_s2, e2_s2);
		end
	end

endmodule
`default_nettype wire

FILE: design/ntc_d2t_log_step.sv
// One squaring step of the log2 fraction: yields one fraction bit.
`default_nettype none
module ntc_d2t_log_step #(
	parameter int BIT = 29
) (
	input  wire logic clk,
	input  wire logic adv,
	input  wire logic [ntc_d2t_pkg::MANT_W-1:0]   m_in,
	input  wire logic [ntc_d2t_pkg::LOG_FRAC-1:0] frac_in,
	output logic [ntc_d2t_pkg::MANT_W-1:0]        m_s,
	output logic [ntc_d2t_pkg::LOG_FRAC-1:0]      frac_s
);
	localparam int MW = ntc_d2t_pkg::MANT_W;
	localparam int LF = ntc_d2t_pkg::LOG_FRAC;

	logic [2*MW-1:0] sq_c;
	logic [MW:0]     t_c;
	logic [LF-1:0]   frac_c;

	assign sq_c = (2*MW)'(m_in) * (2*MW)'(m_in);
	assign t_c  = sq_c[LF +: MW+1];

	always_comb begin
		frac_c      = frac_in;
		frac_c[BIT] = t_c[MW];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frac_s <= frac_c;
			// square reached two: halve back into range
			m_s <= t_c[MW] ? t_c[MW:1] : t_c[MW-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: design/ntc_d2t_div_step.sv
// One restoring-division step producing one quotient bit.
`default_nettype none
module ntc_d2t_div_step #(
	parameter int DW  = 45,
	parameter int BIT = 15
) (
	input  wire logic clk,
	input  wire logic adv,
	input  wire logic [ntc_d2t_pkg::REM_W-1:0]  rem_in,
	input  wire logic [DW-1:0]                  den_in,
	input  wire logic [ntc_d2t_pkg::QUOT_W-1:0] q_in,
	output logic [ntc_d2t_pkg::REM_W-1:0]       rem_s,
	output logic [DW-1:0]                       den_s,
	output logic [ntc_d2t_pkg::QUOT_W-1:0]      q_s
);
	localparam int RW = ntc_d2t_pkg::REM_W;
	localparam int QW = ntc_d2t_pkg::QUOT_W;

	logic [RW-1:0] dsh_c;
	logic          ge_c;
	logic [QW-1:0] q_c;

	assign dsh_c = RW'(den_in) << BIT;
	assign ge_c  = rem_in >= dsh_c;

	always_comb begin
		q_c      = q_in;
		q_c[BIT] = ge_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s  <= den_in;
			q_s    <= q_c;
			rem_s  <= ge_c ? (rem_in - dsh_c) : rem_in;
		end
	end

endmodule
`default_nettype wire

FILE: design/ntc_duty_to_temperature_core.sv
// Top level: NTC thermistor temperature from a PWM duty ratio, fully pipelined.
//
// Input channel: duty (unsigned fraction of one, DUTY_WIDTH bits) with
// in_valid / in_stall. Output channel: temperature_centi (0.01 degC,
// 0..20000) and valid_res with out_valid / out_stall. Each accepted duty
// gives exactly one result; valid_res is 0 (and the temperature 0) when
// the duty lies outside [duty_min, duty_max].
// The pipeline has 3 front-end stages, 30 log2 squaring stages,
// 6 stages for the beta term and saturation check, 16 restoring division
// stages and the output register. One item enters every cycle unless stalled.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (0 duty_min, 1 duty_max, 2 nominal resistance, 3 beta); write only while
// the pipeline is empty.
// Reset restores the default registers and clears every stage valid bit.
// While out_stall holds a waiting result the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
`default_nettype none
module ntc_duty_to_temperature_core #(
	parameter int DUTY_WIDTH = ntc_d2t_pkg::DUTY_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [DUTY_WIDTH-1:0]  duty,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [14:0]                 temperature_centi,
	output logic                        valid_res,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [ntc_d2t_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int XW = DUTY_WIDTH + 23;
	localparam int EW = $clog2(XW);
	localparam int LF = ntc_d2t_pkg::LOG_FRAC;
	localparam int MW = ntc_d2t_pkg::MANT_W;
	localparam int LW = EW + LF;
	localparam int PW = LW + 24;
	localparam int TW = PW - 16;
	localparam int DW = ((TW > 44) ? TW : 44) + 1;
	localparam int RW = ntc_d2t_pkg::REM_W;
	localparam int QW = ntc_d2t_pkg::QUOT_W;
	localparam int HW = LW - 18;

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// configuration registers
	logic [15:0] duty_min_q, duty_max_q;
	logic [16:0] r25_q;
	logic [13:0] beta_q;
	logic [16:0] r25_eff;
	logic [13:0] beta_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_min_q <= ntc_d2t_pkg::DUTY_MIN_RST;
			duty_max_q <= ntc_d2t_pkg::DUTY_MAX_RST;
			r25_q      <= ntc_d2t_pkg::R25_RST;
			beta_q     <= ntc_d2t_pkg::BETA_RST;
		end else if (cfg_we) begin
			case (ntc_d2t_pkg::cfg_reg_t'(cfg_index))
				ntc_d2t_pkg::REG_DUTY_MIN: duty_min_q <= cfg_data[15:0];
				ntc_d2t_pkg::REG_DUTY_MAX: duty_max_q <= cfg_data[15:0];
				ntc_d2t_pkg::REG_R25:      r25_q      <= cfg_data[16:0];
				ntc_d2t_pkg::REG_BETA:     beta_q     <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	assign r25_eff  = (r25_q == '0) ? 17'd1 : r25_q;
	assign beta_eff = (beta_q == '0) ? 14'd1 : beta_q;

	// front end
	ntc_d2t_pkg::ctl_t ctl_s3;
	logic [EW-1:0] e1_s3, e2_s3;
	logic [MW-1:0] m1_s3, m2_s3;

	ntc_d2t_front #(.DUTY_WIDTH(DUTY_WIDTH), .XW(XW), .EW(EW)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(in_valid), .duty(duty),
		.duty_min(duty_min_q), .duty_max(duty_max_q), .r25(r25_eff),
		.ctl_s3(ctl_s3), .e1_s3(e1_s3), .e2_s3(e2_s3), .m1_s3(m1_s3), .m2_s3(m2_s3)
	);

	// log2 squaring stages for both logs
	ntc_d2t_pkg::ctl_t lctl_s [LF+1];
	logic [EW-1:0] le1_s [LF+1];
	logic [EW-1:0] le2_s [LF+1];
	logic [MW-1:0] lm1_s [LF+1];
	logic [MW-1:0] lm2_s [LF+1];
	logic [LF-1:0] lf1_s [LF+1];
	logic [LF-1:0] lf2_s [LF+1];

	assign lctl_s[0] = ctl_s3;
	assign le1_s[0]  = e1_s3;
	assign le2_s[0]  = e2_s3;
	assign lm1_s[0]  = m1_s3;
	assign lm2_s[0]  = m2_s3;
	assign lf1_s[0]  = '0;
	assign lf2_s[0]  = '0;

	for (genvar k = 0; k < LF; k++) begin : g_log
		ntc_d2t_log_step #(.BIT(LF - 1 - k)) u_l1 (
			.clk(clk), .adv(adv), .m_in(lm1_s[k]), .frac_in(lf1_s[k]),
			.m_s(lm1_s[k+1]), .frac_s(lf1_s[k+1])
		);
		ntc_d2t_log_step #(.BIT(LF - 1 - k)) u_l2 (
			.clk(clk), .adv(adv), .m_in(lm2_s[k]), .frac_in(lf2_s[k]),
			.m_s(lm2_s[k+1]), .frac_s(lf2_s[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				lctl_s[k+1] <= '0;
			else if (adv)
				lctl_s[k+1] <= lctl_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				le1_s[k+1] <= le1_s[k];
				le2_s[k+1] <= le2_s[k];
			end
		end
	end

	// log difference, beta term and saturation check
	ntc_d2t_pkg::ctl_t ctl_l_s, ctl_p_s, ctl_t_s, ctl_d_s, ctl_n_s, ctl_f_s;
	logic [LW:0]   l_c;
	logic          neg_l_s, neg_p_s;
	logic [LW-1:0] mag_l_s;
	logic [41:0]   pp_lo_p_s;
	logic [HW+23:0] pp_hi_p_s;
	logic [TW-1:0] term_t_s;
	logic          neg_t_s;
	logic [PW-1:0] prod_c;
	logic [DW-1:0] b30_c;
	logic [DW-1:0] den_d_s, den_n_s, den_f_s;
	logic          pos_d_s, pos_n_s;
	logic [RW-1:0] n_n_s, lim_n_s, n_f_s;
	logic          sat_f_s;

	assign l_c    = (LW+1)'({le1_s[LF], lf1_s[LF]}) - (LW+1)'({le2_s[LF], lf2_s[LF]});
	assign prod_c = PW'(pp_lo_p_s) + (PW'(pp_hi_p_s) << 18);
	assign b30_c  = DW'(beta_eff) << LF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_l_s <= '0;
			ctl_p_s <= '0;
			ctl_t_s <= '0;
			ctl_d_s <= '0;
			ctl_n_s <= '0;
			ctl_f_s <= '0;
		end else if (adv) begin
			ctl_l_s <= lctl_s[LF];
			ctl_p_s <= ctl_l_s;
			ctl_t_s <= ctl_p_s;
			ctl_d_s <= ctl_t_s;
			ctl_n_s <= ctl_d_s;
			ctl_f_s <= ctl_n_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_l_s   <= l_c[LW];
			mag_l_s   <= l_c[LW] ? LW'(-l_c) : l_c[LW-1:0];
			neg_p_s   <= neg_l_s;
			pp_lo_p_s <= 42'(ntc_d2t_pkg::K_T25_LN2) * 42'(mag_l_s[17:0]);
			pp_hi_p_s <= (HW+24)'(ntc_d2t_pkg::K_T25_LN2) * (HW+24)'(mag_l_s[LW-1:18]);
			neg_t_s   <= neg_p_s;
			term_t_s  <= prod_c[PW-1:16];
			// a non-positive denominator means the temperature runs off high
			pos_d_s   <= !neg_t_s || (b30_c > DW'(term_t_s));
			den_d_s   <= neg_t_s ? (b30_c - DW'(term_t_s)) : (b30_c + DW'(term_t_s));
			pos_n_s   <= pos_d_s;
			den_n_s   <= den_d_s;
			n_n_s     <= (RW'(RW'(ntc_d2t_pkg::T25_CENTI_K) * RW'(beta_eff)) << LF)
			             + RW'(den_d_s >> 1);
			lim_n_s   <= RW'(den_d_s) * RW'(ntc_d2t_pkg::SAT_LIMIT);
			sat_f_s   <= !pos_n_s || (n_n_s >= lim_n_s);
			n_f_s     <= n_n_s;
			den_f_s   <= den_n_s;
		end
	end

	// quotient stages
	ntc_d2t_pkg::ctl_t dctl_s [QW+1];
	logic          dsat_s [QW+1];
	logic [RW-1:0] drem_s [QW+1];
	logic [DW-1:0] dden_s [QW+1];
	logic [QW-1:0] dq_s   [QW+1];

	assign dctl_s[0] = ctl_f_s;
	assign dsat_s[0] = sat_f_s;
	assign drem_s[0] = n_f_s;
	assign dden_s[0] = den_f_s;
	assign dq_s[0]   = '0;

	for (genvar k = 0; k < QW; k++) begin : g_div
		ntc_d2t_div_step #(.DW(DW), .BIT(QW - 1 - k)) u_div (
			.clk(clk), .adv(adv), .rem_in(drem_s[k]), .den_in(dden_s[k]),
			.q_in(dq_s[k]), .rem_s(drem_s[k+1]), .den_s(dden_s[k+1]), .q_s(dq_s[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dctl_s[k+1] <= '0;
			else if (adv)
				dctl_s[k+1] <= dctl_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv)
				dsat_s[k+1] <= dsat_s[k];
		end
	end

	// output register
	logic [QW-1:0] tk_c;
	logic [14:0]   temp_c;

	assign tk_c = dq_s[QW];

	always_comb begin
		if (!dctl_s[QW].ok)
			temp_c = '0;
		else if (dsat_s[QW])
			temp_c = ntc_d2t_pkg::TEMP_MAX_CENTI;
		else if (tk_c <= ntc_d2t_pkg::ZERO_C_CENTI_K)
			temp_c = '0;
		else if ((tk_c - ntc_d2t_pkg::ZERO_C_CENTI_K) > 16'(ntc_d2t_pkg::TEMP_MAX_CENTI))
			temp_c = ntc_d2t_pkg::TEMP_MAX_CENTI;
		else
			temp_c = 15'(tk_c - ntc_d2t_pkg::ZERO_C_CENTI_K);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= dctl_s[QW].vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temperature_centi <= temp_c;
			valid_res         <= dctl_s[QW].ok;
		end
	end

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> temperature_centi == '0)
		else $error("out-of-window result carries a temperature");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi <= ntc_d2t_pkg::TEMP_MAX_CENTI)
		else $error("temperature above saturation limit");

	a_nonpos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !pos_n_s |=> sat_f_s)
		else $error("non-positive denominator not saturated");

endmodule
`default_nettype wire
